// ===== src/i2ctpb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2ctpb_pkg
// Types and codes shared by the I2C target pointer buffer modules.
// ----------------------------------------------------------------------------
package i2ctpb_pkg;

    // default store depth in bytes
    localparam int BUFFER_SIZE_DEF = 32;

    // pointer value that means undefined
    localparam logic [7:0] PTR_UNDEF = 8'hFF;

    // event codes on the input word
    localparam logic [2:0] REQ_ADDR_WRITE = 3'd0;
    localparam logic [2:0] REQ_BYTE_RX    = 3'd1;
    localparam logic [2:0] REQ_BYTE_TX    = 3'd2;
    localparam logic [2:0] REQ_XFER_END   = 3'd3;
    localparam logic [2:0] REQ_HOST_WR    = 3'd4;
    localparam logic [2:0] REQ_HOST_RD    = 3'd5;
    localparam logic [2:0] REQ_POLL       = 3'd6;

    // store operations handed from front to back
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_WR_RX = 3'd1;
    localparam logic [2:0] OP_WR_TX = 3'd2;
    localparam logic [2:0] OP_RD_RX = 3'd3;
    localparam logic [2:0] OP_RD_TX = 3'd4;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] bus_byte;
        logic [7:0] host_index;
        logic [7:0] host_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] send_byte;
        logic       acknowledge;
        logic       data_ready;
        logic [7:0] host_read_byte;
    } t_out;

    // classified command between front and back
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] addr;
        logic [7:0] wdata;
        logic       ack;
        logic       ready;
    } t_cmd;

endpackage

// ===== src/i2c_target_pointer_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_target_pointer_buffer_unit
// Byte-level I2C target back end with receive and transmit byte stores.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_word) carries one event per
// word: addressed for write, byte received, byte requested, transfer end,
// host write, host read or poll. Output channel (o_out_valid / i_out_stall /
// o_out_word) returns exactly one result word per event, in order.
// Throughput: one word per cycle in steady state while the receiver does
// not stall. Each event passes the command queue, then the store read
// stage, whose registered RAM read forms the result word.
// The front end keeps the bus pointers and ready flag and accepts words as
// long as its two-entry command queue has room; the back end drains the
// queue into the stores. When the receiver stalls, the result word holds,
// the queue fills and o_in_stall rises once the queue holds two words.
// Reset (synchronous, active low) sets both pointers undefined, clears the
// ready flag and marks every store entry unwritten, so both stores read as
// zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_target_pointer_buffer_unit
    import i2ctpb_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_word,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_word
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic take;

    // front accepts while the queue has room
    assign o_in_stall = q_full;
    assign take       = i_in_valid && !q_full;

    i2ctpb_front #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_word  (i_in_word),
        .o_cmd   (front_cmd)
    );

    i2ctpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (queue_cmd)
    );

    i2ctpb_back #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (queue_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_word    (o_out_word)
    );

endmodule

// ===== src/i2ctpb_ram.sv =====
// ----------------------------------------------------------------------------
// i2ctpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2ctpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port, data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/i2ctpb_front.sv =====
// ----------------------------------------------------------------------------
// i2ctpb_front
// Classifies each event, keeps the bus pointers and the ready flag, and
// turns the event into one store command for the back end.
// ----------------------------------------------------------------------------
module i2ctpb_front
    import i2ctpb_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_take,
    input  t_in  i_word,
    output t_cmd o_cmd
);

    localparam logic [8:0] SIZE9 = 9'(BUFFER_SIZE);

    logic [7:0] r_rx_ptr, n_rx_ptr;
    logic [7:0] r_tx_ptr, n_tx_ptr;
    logic       r_ready_flag, n_ready_flag;
    logic [7:0] tx_start;
    logic       rx_in_range;
    logic       tx_in_range;
    logic       bus_in_range;
    logic       host_in_range;

    assign tx_start      = (r_tx_ptr == PTR_UNDEF) ? 8'd0 : r_tx_ptr;
    assign rx_in_range   = {1'b0, r_rx_ptr} < SIZE9;
    assign tx_in_range   = {1'b0, tx_start} < SIZE9;
    assign bus_in_range  = {1'b0, i_word.bus_byte} < SIZE9;
    assign host_in_range = {1'b0, i_word.host_index} < SIZE9;

    // event decode and pointer update
    always_comb begin
        n_rx_ptr     = r_rx_ptr;
        n_tx_ptr     = r_tx_ptr;
        n_ready_flag = r_ready_flag;
        o_cmd        = '0;
        o_cmd.op     = OP_NONE;
        case (i_word.req_type)
            REQ_ADDR_WRITE: begin
                n_rx_ptr  = PTR_UNDEF;
                o_cmd.ack = 1'b1;
            end
            REQ_BYTE_RX: begin
                o_cmd.ack = 1'b1;
                if (r_rx_ptr == PTR_UNDEF) begin
                    n_rx_ptr = bus_in_range ? i_word.bus_byte : 8'd0;
                end else begin
                    if (rx_in_range) begin
                        o_cmd.op    = OP_WR_RX;
                        o_cmd.addr  = r_rx_ptr;
                        o_cmd.wdata = i_word.bus_byte;
                    end
                    n_rx_ptr = r_rx_ptr + 8'd1;
                end
            end
            REQ_BYTE_TX: begin
                o_cmd.ack = 1'b1;
                n_tx_ptr  = tx_start;
                if (tx_in_range) begin
                    o_cmd.op   = OP_RD_TX;
                    o_cmd.addr = tx_start;
                    n_tx_ptr   = tx_start + 8'd1;
                end
            end
            REQ_XFER_END: begin
                n_ready_flag = 1'b1;
                n_tx_ptr     = PTR_UNDEF;
            end
            REQ_HOST_WR: begin
                if (host_in_range) begin
                    o_cmd.op    = OP_WR_TX;
                    o_cmd.addr  = i_word.host_index;
                    o_cmd.wdata = i_word.host_byte;
                end
            end
            REQ_HOST_RD: begin
                if (host_in_range) begin
                    o_cmd.op   = OP_RD_RX;
                    o_cmd.addr = i_word.host_index;
                end
            end
            REQ_POLL: begin
                o_cmd.ready  = r_ready_flag;
                n_ready_flag = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // pointer and flag registers, updated only on a taken word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_ptr     <= PTR_UNDEF;
            r_tx_ptr     <= PTR_UNDEF;
            r_ready_flag <= 1'b0;
        end else if (i_take) begin
            r_rx_ptr     <= n_rx_ptr;
            r_tx_ptr     <= n_tx_ptr;
            r_ready_flag <= n_ready_flag;
        end
    end

endmodule

// ===== src/i2ctpb_queue.sv =====
// ----------------------------------------------------------------------------
// i2ctpb_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module i2ctpb_queue
    import i2ctpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

// ===== src/i2ctpb_back.sv =====
// ----------------------------------------------------------------------------
// i2ctpb_back
// Carries out store commands on the receive and transmit RAMs and forms the
// result word; the read stage doubles as the output register.
// ----------------------------------------------------------------------------
module i2ctpb_back
    import i2ctpb_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_word
);

    localparam int AW = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;

    logic [BUFFER_SIZE-1:0] r_rx_vld;
    logic [BUFFER_SIZE-1:0] r_tx_vld;
    logic                   r_b_valid;
    logic [2:0]             r_b_op;
    logic                   r_b_ack;
    logic                   r_b_ready;
    logic                   r_b_hit;
    logic                   stage_free;
    logic [AW-1:0]          addr;
    logic                   rx_wr, tx_wr, rx_rd, tx_rd;
    logic [7:0]             rx_rdata, tx_rdata;

    // issue one command whenever the result stage can take it
    assign stage_free = !r_b_valid || !i_stall;
    assign o_pop      = !i_q_empty && stage_free;
    assign addr       = i_cmd.addr[AW-1:0];
    assign rx_wr      = o_pop && (i_cmd.op == OP_WR_RX);
    assign tx_wr      = o_pop && (i_cmd.op == OP_WR_TX);
    assign rx_rd      = o_pop && (i_cmd.op == OP_RD_RX);
    assign tx_rd      = o_pop && (i_cmd.op == OP_RD_TX);

    i2ctpb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_SIZE),
        .AW    (AW)
    ) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rx_wr),
        .i_wr_addr (addr),
        .i_wr_data (i_cmd.wdata),
        .i_rd_en   (rx_rd),
        .i_rd_addr (addr),
        .o_rd_data (rx_rdata)
    );

    i2ctpb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_SIZE),
        .AW    (AW)
    ) u_tx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tx_wr),
        .i_wr_addr (addr),
        .i_wr_data (i_cmd.wdata),
        .i_rd_en   (tx_rd),
        .i_rd_addr (addr),
        .o_rd_data (tx_rdata)
    );

    // per-entry written flags, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_vld <= '0;
            r_tx_vld <= '0;
        end else begin
            if (rx_wr) begin
                r_rx_vld[addr] <= 1'b1;
            end
            if (tx_wr) begin
                r_tx_vld[addr] <= 1'b1;
            end
        end
    end

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (stage_free) begin
            r_b_valid <= o_pop;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_op    <= i_cmd.op;
            r_b_ack   <= i_cmd.ack;
            r_b_ready <= i_cmd.ready;
            r_b_hit   <= (i_cmd.op == OP_RD_RX) ? r_rx_vld[addr] : r_tx_vld[addr];
        end
    end

    // result word
    assign o_valid               = r_b_valid;
    assign o_word.send_byte      = (r_b_op == OP_RD_TX && r_b_hit) ? tx_rdata : 8'd0;
    assign o_word.acknowledge    = r_b_ack;
    assign o_word.data_ready     = r_b_ready;
    assign o_word.host_read_byte = (r_b_op == OP_RD_RX && r_b_hit) ? rx_rdata : 8'd0;

    // a read is issued only when the result stage moves on
    a_rd_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_rd || tx_rd) |-> stage_free)
        else $error("store read while result stage is stalled");
    // a stalled result keeps its read data
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && i_stall) |=> $stable(o_word))
        else $error("result changed while stalled");
    // poll answer and acknowledge never come together
    a_ready_no_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> !(o_word.data_ready && o_word.acknowledge))
        else $error("ready and acknowledge in one word");

endmodule

// ===== sim/i2c_target_pointer_buffer_monitor.sv =====
// ----------------------------------------------------------------------------
// i2c_target_pointer_buffer_monitor
// Watches both channels of the I2C target pointer buffer, keeps a mirror of
// its stores, pointers and ready flag, and checks every result word.
// ----------------------------------------------------------------------------
module i2c_target_pointer_buffer_monitor
    import i2ctpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_word,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_word,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = BUFFER_SIZE_DEF;

    // mirror of the block state
    logic [7:0] rx_image [0:DEPTH-1];
    logic [7:0] tx_image [0:DEPTH-1];
    logic [7:0] rx_ptr;
    logic [7:0] tx_ptr;
    logic       end_seen;

    // result words still owed by the block, oldest first
    t_out pending_replies [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one line per wrong field
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch in %s: got %02h, want %02h", $time, what, got, want);
        o_fail_count++;
    endtask

    // apply one event to the mirror and return the word it should produce
    function automatic t_out buffer_event(input t_in w);
        t_out r;
        r = '0;
        case (w.req_type)
            REQ_ADDR_WRITE: begin
                rx_ptr        = PTR_UNDEF;
                r.acknowledge = 1'b1;
            end
            REQ_BYTE_RX: begin
                // first byte after addressing sets the pointer
                if (rx_ptr == PTR_UNDEF) begin
                    rx_ptr = (w.bus_byte < DEPTH) ? w.bus_byte : 8'd0;
                end else begin
                    if (rx_ptr < DEPTH) begin
                        rx_image[rx_ptr] = w.bus_byte;
                    end
                    rx_ptr = rx_ptr + 8'd1;
                end
                r.acknowledge = 1'b1;
            end
            REQ_BYTE_TX: begin
                if (tx_ptr == PTR_UNDEF) begin
                    tx_ptr = 8'd0;
                end
                // past the end the pointer holds and zero goes out
                if (tx_ptr < DEPTH) begin
                    r.send_byte = tx_image[tx_ptr];
                    tx_ptr      = tx_ptr + 8'd1;
                end
                r.acknowledge = 1'b1;
            end
            REQ_XFER_END: begin
                end_seen = 1'b1;
                tx_ptr   = PTR_UNDEF;
            end
            REQ_HOST_WR: begin
                if (w.host_index < DEPTH) begin
                    tx_image[w.host_index] = w.host_byte;
                end
            end
            REQ_HOST_RD: begin
                if (w.host_index < DEPTH) begin
                    r.host_read_byte = rx_image[w.host_index];
                end
            end
            REQ_POLL: begin
                r.data_ready = end_seen;
                end_seen     = 1'b0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // check results first, then predict for the accepted event
    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                rx_image[k] = 8'd0;
                tx_image[k] = 8'd0;
            end
            rx_ptr   = PTR_UNDEF;
            tx_ptr   = PTR_UNDEF;
            end_seen = 1'b0;
            pending_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected word", i_out_word.send_byte, 8'd0);
                end else begin
                    want = pending_replies.pop_front();
                    if (i_out_word.send_byte !== want.send_byte) begin
                        report_mismatch("send_byte", i_out_word.send_byte, want.send_byte);
                    end
                    if (i_out_word.acknowledge !== want.acknowledge) begin
                        report_mismatch("acknowledge", {7'd0, i_out_word.acknowledge},
                                        {7'd0, want.acknowledge});
                    end
                    if (i_out_word.data_ready !== want.data_ready) begin
                        report_mismatch("data_ready", {7'd0, i_out_word.data_ready},
                                        {7'd0, want.data_ready});
                    end
                    if (i_out_word.host_read_byte !== want.host_read_byte) begin
                        report_mismatch("host_read_byte", i_out_word.host_read_byte,
                                        want.host_read_byte);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_replies.push_back(buffer_event(i_in_word));
            end
        end
        o_pending = pending_replies.size();
    end

endmodule

// ===== sim/i2c_target_pointer_buffer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_target_pointer_buffer_unit_tb
// Drives bus events and host accesses into the pointer buffer: a directed
// opening, then random write and read transfers, host traffic, polls and
// noise, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module i2c_target_pointer_buffer_unit_tb;
    import i2ctpb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_WORDS = 600;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          DEPTH        = BUFFER_SIZE_DEF;
    // request code with no meaning, the block must ignore it
    localparam logic [2:0]  REQ_UNUSED   = 3'd7;

    typedef enum {SEQ_WRITE, SEQ_READ, SEQ_HOST_WR, SEQ_HOST_RD, SEQ_POLL, SEQ_NOISE} t_seq;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in_word   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_word;

    int   fail_count;
    int   replies_owed;
    int   words_sent  = 0;
    int   cycle_count = 0;
    int   out_hold;
    // when set, neither side idles
    logic quiet       = 1'b0;

    i2c_target_pointer_buffer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    i2c_target_pointer_buffer_monitor monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .o_fail_count (fail_count),
        .o_pending    (replies_owed)
    );

    always #4 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_in make_word(input logic [2:0] req, input logic [7:0] bus,
                                      input logic [7:0] idx, input logic [7:0] hb);
        t_in w;
        w.req_type   = req;
        w.bus_byte   = bus;
        w.host_index = idx;
        w.host_byte  = hb;
        return w;
    endfunction

    // mostly a valid store entry, sometimes anything
    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom);
        end
        return 8'($urandom_range(0, DEPTH - 1));
    endfunction

    // one word on the input channel after a random gap, held until taken
    task automatic put_word(input t_in w);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        words_sent++;
    endtask

    task automatic put_event(input logic [2:0] req);
        put_word(make_word(req, 8'($urandom), pick_index(), 8'($urandom)));
    endtask

    // result side: random stall before each word
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            out_hold = quiet ? 0 : $urandom_range(0, 14);
            if (out_hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (out_hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!o_out_valid);
        end
    end

    initial begin : stimulus
        int   pick;
        int   len;
        int   seq_no;
        t_seq kind;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: host writes at the edges of the transmit store
        put_word(make_word(REQ_HOST_WR, 8'h00, 8'd0, 8'hA5));
        put_word(make_word(REQ_HOST_WR, 8'hFF, 8'd31, 8'hFF));
        put_word(make_word(REQ_HOST_WR, 8'h00, 8'd32, 8'h5A));
        put_word(make_word(REQ_HOST_WR, 8'h00, 8'd255, 8'h00));
        // read from an undefined transmit pointer starts at entry zero
        put_word(make_word(REQ_BYTE_TX, 8'h00, 8'd0, 8'h00));
        put_word(make_word(REQ_BYTE_TX, 8'hFF, 8'hFF, 8'hFF));
        put_word(make_word(REQ_XFER_END, 8'h00, 8'd0, 8'h00));
        // ready flag clears on poll
        put_word(make_word(REQ_POLL, 8'h00, 8'd0, 8'h00));
        put_word(make_word(REQ_POLL, 8'hFF, 8'hFF, 8'hFF));
        // out of range first byte sets the pointer to zero
        put_word(make_word(REQ_ADDR_WRITE, 8'hFF, 8'hFF, 8'hFF));
        put_word(make_word(REQ_BYTE_RX, 8'd255, 8'd0, 8'h00));
        put_word(make_word(REQ_BYTE_RX, 8'hFF, 8'd0, 8'h00));
        put_word(make_word(REQ_BYTE_RX, 8'h00, 8'd0, 8'h00));
        put_word(make_word(REQ_XFER_END, 8'hFF, 8'hFF, 8'hFF));
        // last entry, then two bytes past the end that are dropped
        put_word(make_word(REQ_ADDR_WRITE, 8'h00, 8'd0, 8'h00));
        put_word(make_word(REQ_BYTE_RX, 8'd31, 8'd0, 8'h00));
        put_word(make_word(REQ_BYTE_RX, 8'h81, 8'd0, 8'h00));
        put_word(make_word(REQ_BYTE_RX, 8'h7E, 8'd0, 8'h00));
        put_word(make_word(REQ_BYTE_RX, 8'd32, 8'd0, 8'h00));
        put_word(make_word(REQ_XFER_END, 8'h00, 8'd0, 8'h00));
        // host reads at and past the end of the receive store
        put_word(make_word(REQ_HOST_RD, 8'h00, 8'd0, 8'h00));
        put_word(make_word(REQ_HOST_RD, 8'h00, 8'd31, 8'h00));
        put_word(make_word(REQ_HOST_RD, 8'h00, 8'd32, 8'h00));
        put_word(make_word(REQ_HOST_RD, 8'h00, 8'd255, 8'h00));
        put_word(make_word(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF));

        // random transfers and host traffic
        seq_no = 0;
        len    = 0;
        while (words_sent < RANDOM_WORDS + 25) begin
            pick  = $urandom_range(0, 9);
            kind  = (pick < 3) ? SEQ_WRITE : (pick < 5) ? SEQ_READ :
                    (pick == 5) ? SEQ_HOST_WR : (pick == 6) ? SEQ_HOST_RD :
                    (pick == 7) ? SEQ_POLL : SEQ_NOISE;
            quiet <= ($urandom_range(0, 5) == 0);
            // an early long write makes the receive pointer wrap
            if (seq_no == 2) begin
                kind = SEQ_WRITE;
            end
            case (kind)
                SEQ_WRITE: begin
                    if ($urandom_range(0, 5) != 0) begin
                        put_event(REQ_ADDR_WRITE);
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        put_word(make_word(REQ_BYTE_RX, 8'($urandom), pick_index(),
                                           8'($urandom)));
                    end else begin
                        put_word(make_word(REQ_BYTE_RX, 8'($urandom_range(0, DEPTH - 1)),
                                           pick_index(), 8'($urandom)));
                    end
                    if (seq_no == 2 || $urandom_range(0, 39) == 0) begin
                        len = $urandom_range(260, 290);
                    end else begin
                        len = $urandom_range(0, 40);
                    end
                    repeat (len) put_event(REQ_BYTE_RX);
                    if ($urandom_range(0, 5) != 0) begin
                        put_event(REQ_XFER_END);
                    end
                end
                SEQ_READ: begin
                    len = $urandom_range(1, 40);
                    repeat (len) put_event(REQ_BYTE_TX);
                    if ($urandom_range(0, 5) != 0) begin
                        put_event(REQ_XFER_END);
                    end
                end
                SEQ_HOST_WR: begin
                    len = $urandom_range(1, 8);
                    repeat (len) put_event(REQ_HOST_WR);
                end
                SEQ_HOST_RD: begin
                    len = $urandom_range(1, 8);
                    repeat (len) put_event(REQ_HOST_RD);
                end
                SEQ_POLL: begin
                    len = $urandom_range(1, 2);
                    repeat (len) put_event(REQ_POLL);
                end
                default: begin
                    len = $urandom_range(1, 6);
                    repeat (len) put_event(3'($urandom_range(0, 7)));
                end
            endcase
            seq_no++;
        end

        // drain and verdict
        i_in_valid <= 1'b0;
        quiet      <= 1'b0;
        while (replies_owed != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
